[hdl/cmc_pkg.sv]
`timescale 1ns / 1ps

package cmc_pkg;

  // Mode codes as they appear on mode_after.
  typedef enum logic [2:0] {
    MODE_MENU   = 3'd0,
    MODE_HIGH   = 3'd1,
    MODE_LOW    = 3'd2,
    MODE_STREAM = 3'd3,
    MODE_FAULT  = 3'd4
  } mode_t;

  // Action codes as they appear on action.
  typedef enum logic [1:0] {
    ACT_MENU   = 2'd0,
    ACT_HEADER = 2'd1,
    ACT_FLASH  = 2'd2,
    ACT_FAULT  = 2'd3
  } action_t;

  localparam logic [7:0]  ENTER_FIRST  = 8'hAA;
  localparam logic [7:0]  ENTER_SECOND = 8'h55;
  localparam logic [7:0]  EXIT_FIRST   = 8'h81;
  localparam logic [7:0]  EXIT_SECOND  = 8'h66;
  localparam int          STRIDE_SHIFT = 13;      // one file spans 0x2000 bytes
  localparam int          FLASH_AW     = 24;
  localparam logic [15:0] COUNT_LIMIT  = 16'hE000;

  typedef struct packed {
    mode_t       mode;
    logic        enter_armed;
    logic        exit_armed;
    logic [15:0] file_number;
    logic [15:0] byte_count;
  } ctl_state_t;

  typedef struct packed {
    action_t             action;
    logic [7:0]          menu_index;
    logic [FLASH_AW-1:0] flash_address;
    mode_t               mode_after;
  } result_t;

endpackage

[hdl/cmc_step.sv]
`timescale 1ns / 1ps

// Next-state and result logic for one bus strobe.
module cmc_step import cmc_pkg::*; (
  input  ctl_state_t state,
  input  logic [7:0] bus_address,
  output ctl_state_t state_next,
  output result_t    result
);

  logic [15:0]         count_inc;
  logic [FLASH_AW-1:0] file_base;
  logic                leave;

  // The file base is file_number * 0x2000 taken modulo 2^24.
  assign file_base = {state.file_number[FLASH_AW-STRIDE_SHIFT-1:0], {STRIDE_SHIFT{1'b0}}};
  assign count_inc = state.byte_count + 16'd1;

  always_comb begin
    state_next           = state;
    leave                = 1'b0;
    result.action        = ACT_FAULT;
    result.menu_index    = '0;
    result.flash_address = '0;

    case (state.mode)
      MODE_MENU: begin
        result.action     = ACT_MENU;
        result.menu_index = bus_address;
        if (bus_address == ENTER_FIRST) begin
          state_next.enter_armed = 1'b1;
        end else if (bus_address == ENTER_SECOND && state.enter_armed) begin
          state_next.enter_armed = 1'b0;
          state_next.exit_armed  = 1'b0;
          state_next.byte_count  = '0;
          state_next.mode        = MODE_HIGH;
        end else begin
          state_next.enter_armed = 1'b0;
        end
      end
      MODE_HIGH: begin
        result.action                = ACT_HEADER;
        state_next.file_number[15:8] = bus_address;
        state_next.mode              = MODE_LOW;
      end
      MODE_LOW: begin
        result.action               = ACT_HEADER;
        state_next.file_number[7:0] = bus_address;
        state_next.mode             = MODE_STREAM;
      end
      MODE_STREAM: begin
        result.action        = ACT_FLASH;
        result.flash_address = file_base + {{(FLASH_AW-16){1'b0}}, state.byte_count};
        if (bus_address == EXIT_FIRST) begin
          state_next.exit_armed = 1'b1;
        end else if (bus_address == EXIT_SECOND && state.exit_armed) begin
          state_next.exit_armed = 1'b0;
          leave                 = 1'b1;
        end else begin
          state_next.exit_armed = 1'b0;
        end
        state_next.byte_count = count_inc;
        if (leave) begin
          state_next.enter_armed = 1'b0;
          state_next.mode        = MODE_MENU;
        end else if (count_inc == COUNT_LIMIT) begin
          state_next.mode = MODE_FAULT;
        end
      end
      default: begin
        state_next.mode = MODE_FAULT;
      end
    endcase

    result.mode_after = state_next.mode;
  end

endmodule

[hdl/cartridge_mode_controller.sv]
`timescale 1ns / 1ps

// Cartridge mode controller. Each input transfer carries the decoded low address
// byte of one bus strobe, and each one yields exactly one output transfer that
// tells the rest of the cartridge what to do with that strobe: present a menu
// ROM byte, note a captured header byte, read a flash byte at a 24-bit address,
// or report the sticky fault. The block sits in menu mode after reset; the strobe
// pair 0xAA, 0x55 enters header mode, the next two strobes give the file number
// high byte first, and stream mode then walks the flash from file * 0x2000 until
// the pair 0x81, 0x66 returns to the menu. Reaching 0xE000 bytes in one stream
// without that exit locks the block in fault mode until reset. Throughput is one
// transfer per clock while out_stall is low. An input transfer lands in the
// input register, the mode decision runs between it and the result register,
// and the registered result is then offered at the output. An input transfer is
// taken while a finished result still waits in the result register, as long
// as the input register is free.
module cartridge_mode_controller import cmc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          bus_address,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          action,
  output logic [7:0]          menu_index,
  output logic [FLASH_AW-1:0] flash_address,
  output logic [2:0]          mode_after
);

  logic       in_full;
  logic [7:0] in_addr;
  ctl_state_t state;
  ctl_state_t state_next;
  result_t    step_result;
  result_t    result;
  logic       advance;
  logic       in_take;

  // The result register can load when it is empty or being emptied this cycle.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  cmc_step u_step (
    .state      (state),
    .bus_address(in_addr),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full     <= 1'b0;
      out_valid   <= 1'b0;
      state.mode  <= MODE_MENU;
      state.enter_armed <= 1'b0;
      state.exit_armed  <= 1'b0;
      state.file_number <= '0;
      state.byte_count  <= '0;
    end else begin
      if (in_take) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      // The mode state moves only when an item passes into the result register.
      if (in_full && advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (advance) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_addr <= bus_address;
    end
    if (in_full && advance) begin
      result <= step_result;
    end
  end

  assign action        = result.action;
  assign menu_index    = result.menu_index;
  assign flash_address = result.flash_address;
  assign mode_after    = result.mode_after;

endmodule

[hdl/cmc_checker.sv]
`timescale 1ns / 1ps

// Port-level checks for the cartridge mode controller.
module cmc_checker import cmc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          action,
  input logic [7:0]          menu_index,
  input logic [FLASH_AW-1:0] flash_address,
  input logic [2:0]          mode_after
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transfer withdrawn while stalled");

  // A fault answer always reports fault mode.
  a_fault_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_FAULT |-> mode_after == MODE_FAULT)
    else $error("fault action without fault mode");

  // A menu read leaves the block in the menu or starting the header.
  a_menu_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_MENU |-> mode_after == MODE_MENU || mode_after == MODE_HIGH)
    else $error("menu read with unexpected mode");

  // Fields that do not belong to the action read as zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (action == ACT_FLASH || flash_address == '0) &&
                  (action == ACT_MENU || menu_index == '0))
    else $error("unused result field not zero");

endmodule

bind cartridge_mode_controller cmc_checker u_cmc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .action       (action),
  .menu_index   (menu_index),
  .flash_address(flash_address),
  .mode_after   (mode_after)
);
